// ----- hw/rtl/bim_pkg.sv -----
package bim_pkg;

    localparam int SIDE_BITS       = 3;
    localparam int SIDE_CELLS      = 1 << SIDE_BITS;
    localparam int SITE_BITS       = 3 * SIDE_BITS + 1;
    localparam int SITE_COUNT      = 2 * SIDE_CELLS * SIDE_CELLS * SIDE_CELLS;
    localparam int EXP_IDX_BITS    = 8;
    localparam int EXP_TABLE_DEPTH = 1 << EXP_IDX_BITS;

    // Read sequence: the site itself, then 8 first and 6 second neighbors.
    localparam int NBR_COUNT      = 15;
    localparam int NBR_BITS       = 4;
    localparam int NBR_FIRST_LAST = 8;
    localparam int NBR_SECOND_0   = 9;

    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUPLING_FIRST  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_COUPLING_SECOND = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FIELD_STRENGTH  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_INV_TEMPERATURE = 2'd3;

    // Terms of the series for exp(-1/16) in Q2.62; term n is term n-1 over 16*n.
    localparam longint unsigned EXP_T0  = 64'd1 << 62;
    localparam longint unsigned EXP_T1  = EXP_T0 / 64'd16;
    localparam longint unsigned EXP_T2  = EXP_T1 / 64'd32;
    localparam longint unsigned EXP_T3  = EXP_T2 / 64'd48;
    localparam longint unsigned EXP_T4  = EXP_T3 / 64'd64;
    localparam longint unsigned EXP_T5  = EXP_T4 / 64'd80;
    localparam longint unsigned EXP_T6  = EXP_T5 / 64'd96;
    localparam longint unsigned EXP_T7  = EXP_T6 / 64'd112;
    localparam longint unsigned EXP_T8  = EXP_T7 / 64'd128;
    localparam longint unsigned EXP_T9  = EXP_T8 / 64'd144;
    localparam longint unsigned EXP_T10 = EXP_T9 / 64'd160;
    localparam longint unsigned EXP_T11 = EXP_T10 / 64'd176;
    localparam longint unsigned EXP_POS = EXP_T0 + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8
                                        + EXP_T10;
    localparam longint unsigned EXP_NEG = EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9
                                        + EXP_T11;
    localparam longint unsigned EXP_R   = ((EXP_POS - EXP_NEG) + (64'd1 << 29)) >> 30;

    typedef logic [EXP_TABLE_DEPTH-1:0][31:0] t_exp_table;

    typedef struct packed {
        logic                 clear_wr;
        logic [SITE_BITS-1:0] clear_addr;
        logic                 load;
        logic                 capture;
        logic                 rd_en;
        logic [NBR_BITS-1:0]  rd_idx;
        logic                 acc_en;
        logic [NBR_BITS-1:0]  acc_idx;
        logic                 mul;
        logic                 sum;
        logic                 prod;
        logic                 decide;
    } t_cmd;

    // Entry k holds exp(-k/16) in Q0.32, built from a series for exp(-1/16).
    function automatic t_exp_table build_exp_table();
        t_exp_table        tab;
        longint unsigned   val;
        val = 64'd1 << 32;
        for (int k = 0; k < EXP_TABLE_DEPTH; k++) begin
            tab[k] = (val > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : val[31:0];
            val    = (val * EXP_R + 64'h8000_0000) >> 32;
        end
        return tab;
    endfunction

    localparam t_exp_table EXP_TABLE = build_exp_table();

endpackage

// ----- hw/rtl/bim_ctrl.sv -----
module bim_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  logic          i_func,
    output logic          busy,
    output bim_pkg::t_cmd o_cmd
);
    import bim_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_READ  = 3'd2;
    localparam logic [2:0] S_MUL   = 3'd3;
    localparam logic [2:0] S_SUM   = 3'd4;
    localparam logic [2:0] S_PROD  = 3'd5;
    localparam logic [2:0] S_DEC   = 3'd6;

    logic [2:0]           r_state;
    logic [2:0]           n_state;
    logic [SITE_BITS-1:0] r_cnt;
    logic [SITE_BITS-1:0] n_cnt;

    always_comb begin
        n_state          = r_state;
        n_cnt            = r_cnt;
        o_cmd            = '0;
        o_cmd.clear_addr = r_cnt;
        o_cmd.rd_idx     = r_cnt[NBR_BITS-1:0];
        o_cmd.acc_idx    = r_cnt[NBR_BITS-1:0] - NBR_BITS'(1);
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clear_wr = 1'b1;
                n_cnt          = r_cnt + SITE_BITS'(1);
                if (r_cnt == SITE_BITS'(SITE_COUNT - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_func) begin
                        o_cmd.capture = 1'b1;
                        n_cnt         = '0;
                        n_state       = S_READ;
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            S_READ: begin
                // Read data is registered, so accumulation uses the address of the previous cycle.
                o_cmd.rd_en  = (r_cnt < SITE_BITS'(NBR_COUNT));
                o_cmd.acc_en = (r_cnt != '0);
                n_cnt        = r_cnt + SITE_BITS'(1);
                if (r_cnt == SITE_BITS'(NBR_COUNT)) begin
                    n_cnt   = '0;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUM;
            end
            S_SUM: begin
                o_cmd.sum = 1'b1;
                n_state   = S_PROD;
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = S_DEC;
            end
            S_DEC: begin
                o_cmd.decide = 1'b1;
                n_state      = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign busy = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

endmodule

// ----- hw/rtl/bim_datapath.sv -----
module bim_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  bim_pkg::t_cmd                        i_cmd,
    input  logic [bim_pkg::SITE_BITS-1:0]        i_site,
    input  logic                                 i_spin_value,
    input  logic [31:0]                          i_random_fraction,
    input  logic                                 i_cfg_wr_en,
    input  logic [bim_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [31:0]                          i_cfg_data,
    output logic                                 o_strobe,
    output logic                                 o_accepted,
    output logic                                 o_new_spin,
    output logic signed [2:0]                    o_delta_magnetization,
    output logic signed [39:0]                   o_delta_energy
);
    import bim_pkg::*;

    logic signed [31:0] r_j1;
    logic signed [31:0] r_j2;
    logic signed [31:0] r_h;
    logic [31:0]        r_beta;

    logic                 r_spin_mem [SITE_COUNT];
    logic                 r_rd_data;
    logic                 mem_we;
    logic [SITE_BITS-1:0] mem_addr;
    logic                 mem_wd;
    logic [SITE_BITS-1:0] rd_addr;

    logic [SITE_BITS-1:0] r_site;
    logic [31:0]          r_frac;
    logic                 r_self;
    logic signed [4:0]    r_s1;
    logic signed [3:0]    r_s2;
    logic signed [36:0]   r_p1;
    logic signed [35:0]   r_p2;
    logic signed [37:0]   local_sum;
    logic signed [39:0]   r_de;
    logic [63:0]          r_lo;
    logic [39:0]          r_hi;
    logic [39:0]          q;
    logic                 accept;

    logic                 r_strobe;
    logic                 r_acc;
    logic                 r_new_spin;
    logic signed [2:0]    r_dm;
    logic signed [39:0]   r_de_out;

    // Cell offset of a first neighbor: {-1,0} for corners, {0,+1} for centers.
    function automatic logic [SIDE_BITS-1:0] first_off(input logic a, input logic p);
        logic [SIDE_BITS-1:0] off;
        if (p) begin
            off = a ? SIDE_BITS'(1) : '0;
        end else begin
            off = a ? '0 : '1;
        end
        return off;
    endfunction

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_j1   <= '0;
            r_j2   <= '0;
            r_h    <= '0;
            r_beta <= 32'd65536;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_COUPLING_FIRST:  r_j1   <= i_cfg_data;
                REG_COUPLING_SECOND: r_j2   <= i_cfg_data;
                REG_FIELD_STRENGTH:  r_h    <= i_cfg_data;
                REG_INV_TEMPERATURE: r_beta <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Neighbor address generation.
    always_comb begin
        logic [SIDE_BITS-1:0] x;
        logic [SIDE_BITS-1:0] y;
        logic [SIDE_BITS-1:0] z;
        logic [SIDE_BITS-1:0] dx;
        logic [SIDE_BITS-1:0] dy;
        logic [SIDE_BITS-1:0] dz;
        logic [SIDE_BITS-1:0] step;
        logic [NBR_BITS-1:0]  j;
        logic                 p;
        logic                 np;
        p    = r_site[0];
        z    = r_site[SIDE_BITS:1];
        y    = r_site[2*SIDE_BITS:SIDE_BITS+1];
        x    = r_site[3*SIDE_BITS:2*SIDE_BITS+1];
        dx   = '0;
        dy   = '0;
        dz   = '0;
        np   = p;
        j    = '0;
        step = '0;
        if (i_cmd.rd_idx == '0) begin
            np = p;
        end else if (i_cmd.rd_idx <= NBR_BITS'(NBR_FIRST_LAST)) begin
            j  = i_cmd.rd_idx - NBR_BITS'(1);
            np = ~p;
            dx = first_off(j[2], p);
            dy = first_off(j[1], p);
            dz = first_off(j[0], p);
        end else begin
            j    = i_cmd.rd_idx - NBR_BITS'(NBR_SECOND_0);
            step = j[0] ? SIDE_BITS'(1) : '1;
            priority case (j[2:1])
                2'd0:    dx = step;
                2'd1:    dy = step;
                default: dz = step;
            endcase
        end
        rd_addr = {x + dx, y + dy, z + dz, np};
    end

    assign local_sum = 38'(r_p1) + 38'(r_p2) + 38'(r_h);

    always_comb begin
        q      = 40'(r_lo[63:32]) + r_hi;
        accept = r_de[39] || (r_de == '0) || (r_beta == '0)
              || ((q[39:EXP_IDX_BITS+4] == '0)
                  && (r_frac < EXP_TABLE[q[EXP_IDX_BITS+3:4]]));
    end

    always_comb begin
        mem_we   = 1'b0;
        mem_addr = r_site;
        mem_wd   = 1'b0;
        priority if (i_cmd.clear_wr) begin
            mem_we   = 1'b1;
            mem_addr = i_cmd.clear_addr;
        end else if (i_cmd.load) begin
            mem_we   = 1'b1;
            mem_addr = i_site;
            mem_wd   = i_spin_value;
        end else if (i_cmd.decide && accept) begin
            mem_we = 1'b1;
            mem_wd = ~r_self;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_spin_mem[mem_addr] <= mem_wd;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_spin_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_site <= i_site;
            r_frac <= i_random_fraction;
            r_s1   <= '0;
            r_s2   <= '0;
        end
        if (i_cmd.acc_en) begin
            if (i_cmd.acc_idx == '0) begin
                r_self <= r_rd_data;
            end else if (i_cmd.acc_idx <= NBR_BITS'(NBR_FIRST_LAST)) begin
                r_s1 <= r_rd_data ? r_s1 + 5'sd1 : r_s1 - 5'sd1;
            end else begin
                r_s2 <= r_rd_data ? r_s2 + 4'sd1 : r_s2 - 4'sd1;
            end
        end
        if (i_cmd.mul) begin
            r_p1 <= r_j1 * r_s1;
            r_p2 <= r_j2 * r_s2;
        end
        if (i_cmd.sum) begin
            r_de <= r_self ? (40'(local_sum) <<< 1) : -(40'(local_sum) <<< 1);
        end
        if (i_cmd.prod) begin
            // Split product: low word times beta, high byte times beta.
            r_lo <= r_de[31:0] * r_beta;
            r_hi <= r_de[39:32] * r_beta;
        end
        if (i_cmd.load) begin
            r_acc      <= 1'b0;
            r_new_spin <= i_spin_value;
            r_dm       <= '0;
            r_de_out   <= '0;
        end else if (i_cmd.decide) begin
            r_acc      <= accept;
            r_new_spin <= accept ? ~r_self : r_self;
            r_dm       <= accept ? (r_self ? -3'sd2 : 3'sd2) : 3'sd0;
            r_de_out   <= accept ? r_de : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.load || i_cmd.decide;
        end
    end

    assign o_strobe              = r_strobe;
    assign o_accepted            = r_acc;
    assign o_new_spin            = r_new_spin;
    assign o_delta_magnetization = r_dm;
    assign o_delta_energy        = r_de_out;

endmodule

// ----- hw/rtl/bcc_ising_metropolis_flip_core.sv -----
// Channel   Direction  Signals
// item      in         start, busy, i_func, i_site, i_spin_value, i_random_fraction
// result    out        o_strobe, o_accepted, o_new_spin, o_delta_magnetization,
//                      o_delta_energy
// config    in         i_cfg_wr_en, i_cfg_index, i_cfg_data
//
// After reset all 1024 sites of the spin memory are cleared with busy high.
// A load item writes at its accept edge and its result strobes in the next
// cycle; loads can follow each other every cycle.
// A flip item holds busy through the 15 reads from the single
// spin memory port, then multiply, sum, beta product and decision steps.
// Its result strobes in the cycle busy falls; results cannot be stalled.
module bcc_ising_metropolis_flip_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_func,
    input  logic [bim_pkg::SITE_BITS-1:0]     i_site,
    input  logic                              i_spin_value,
    input  logic [31:0]                       i_random_fraction,
    input  logic                              i_cfg_wr_en,
    input  logic [bim_pkg::CFG_IDX_BITS-1:0]  i_cfg_index,
    input  logic [31:0]                       i_cfg_data,
    output logic                              o_strobe,
    output logic                              o_accepted,
    output logic                              o_new_spin,
    output logic signed [2:0]                 o_delta_magnetization,
    output logic signed [39:0]                o_delta_energy
);
    import bim_pkg::*;

    t_cmd cmd;

    bim_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_func  (i_func),
        .busy    (busy),
        .o_cmd   (cmd)
    );

    bim_datapath u_datapath (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_cmd                 (cmd),
        .i_site                (i_site),
        .i_spin_value          (i_spin_value),
        .i_random_fraction     (i_random_fraction),
        .i_cfg_wr_en           (i_cfg_wr_en),
        .i_cfg_index           (i_cfg_index),
        .i_cfg_data            (i_cfg_data),
        .o_strobe              (o_strobe),
        .o_accepted            (o_accepted),
        .o_new_spin            (o_new_spin),
        .o_delta_magnetization (o_delta_magnetization),
        .o_delta_energy        (o_delta_energy)
    );

endmodule
